[sv/pvkf_pkg.sv]
// Shared types and constants of the position and velocity Kalman filter.
package pvkf_pkg;

	localparam int COV_FRAC = 24;
	localparam int COV_W    = 48;
	localparam int EST_W    = 32;

	localparam logic [1:0] CFG_PROCESS_NOISE     = 2'd0;
	localparam logic [1:0] CFG_MEASUREMENT_NOISE = 2'd1;
	localparam logic [1:0] CFG_SAMPLE_PERIOD     = 2'd2;

	localparam logic [31:0] PROCESS_NOISE_RST     = 32'd65536;
	localparam logic [31:0] MEASUREMENT_NOISE_RST = 32'd65536;
	localparam logic [16:0] SAMPLE_PERIOD_RST     = 17'd655;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_MUL   = 6'b000010,
		ST_MWAIT = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_DWAIT = 6'b010000,
		ST_OUT   = 6'b100000
	} ctrl_state_t;

	typedef enum logic [3:0] {
		S_VP    = 4'd0,
		S_VA    = 4'd1,
		S_T1    = 4'd2,
		S_A     = 4'd3,
		S_AA    = 4'd4,
		S_Q     = 4'd5,
		S_QQ    = 4'd6,
		S_K1E   = 4'd7,
		S_K0E   = 4'd8,
		S_K1P01 = 4'd9,
		S_K1P00 = 4'd10,
		S_OK01  = 4'd11,
		S_OK00  = 4'd12
	} step_t;

	typedef struct packed {
		logic est_shift;
		logic narrow;
	} mul_mode_t;

	typedef struct packed {
		logic  load;
		logic  clear;
		logic  mul_start;
		logic  mul_wb;
		logic  div_start;
		logic  out_load;
		step_t step;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
	} dp_status_t;

	function automatic logic [47:0] mag48(logic signed [47:0] v);
		return v[47] ? 48'(-v) : 48'(v);
	endfunction

endpackage

[sv/pvkf_ifs.sv]
// Valid/ready channel interfaces for measurements, estimates and configuration.
interface pvkf_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] measured_distance;
	logic signed [31:0] measured_accel;
	logic               restart;
	modport source(output valid, measured_distance, measured_accel, restart, input ready);
	modport sink(input valid, measured_distance, measured_accel, restart, output ready);
endinterface

interface pvkf_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] filtered_distance;
	logic signed [31:0] estimated_velocity;
	modport source(output valid, filtered_distance, estimated_velocity, input ready);
	modport sink(input valid, filtered_distance, estimated_velocity, output ready);
endinterface

interface pvkf_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[sv/pvkf_mul.sv]
// Sign-magnitude multiplier: four 24x24 partial products, truncate, saturate.
module pvkf_mul #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  pvkf_pkg::mul_mode_t mode,
	input  logic signed [47:0]  a,
	input  logic signed [47:0]  b,
	output logic signed [47:0]  res,
	output logic                done
);
	import pvkf_pkg::*;

	logic [47:0]        ma_q, mb_q;
	logic               neg_q;
	mul_mode_t          mode_q;
	logic [95:0]        prod_q;
	logic [2:0]         cnt_q;
	logic               busy_q;
	logic signed [47:0] res_q;
	logic               done_q;

	logic [23:0] half_a, half_b;
	logic [47:0] pp;
	logic [95:0] pp_sh;
	logic [95:0] shifted;
	logic [47:0] lim;
	logic        over;
	logic [47:0] fin;

	always_comb begin
		half_a = cnt_q[1] ? ma_q[47:24] : ma_q[23:0];
		half_b = cnt_q[0] ? mb_q[47:24] : mb_q[23:0];
		pp = 48'(half_a) * 48'(half_b);
		case (cnt_q[1:0])
			2'd0: pp_sh = {48'b0, pp};
			2'd1: pp_sh = {24'b0, pp, 24'b0};
			2'd2: pp_sh = {24'b0, pp, 24'b0};
			default: pp_sh = {pp, 48'b0};
		endcase
		shifted = mode_q.est_shift ? (prod_q >> FRAC_BITS) : (prod_q >> COV_FRAC);
		lim = mode_q.narrow ? 48'h0000_8000_0000 : 48'h8000_0000_0000;
		over = shifted >= {48'b0, lim};
		if (over) begin
			fin = neg_q ? 48'(48'd0 - lim) : 48'(lim - 48'd1);
		end else begin
			fin = neg_q ? 48'(48'd0 - shifted[47:0]) : shifted[47:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd0;
			end else if (busy_q) begin
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q   <= mag48(a);
			mb_q   <= mag48(b);
			neg_q  <= a[47] ^ b[47];
			mode_q <= mode;
			prod_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == 3'd4) begin
				res_q <= fin;
			end else begin
				prod_q <= prod_q + pp_sh;
			end
		end
	end

	assign res  = res_q;
	assign done = done_q;

endmodule

[sv/pvkf_div.sv]
// Two-lane restoring divider for the gains, two quotient bits per cycle.
module pvkf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [47:0] num0,
	input  logic signed [47:0] num1,
	input  logic signed [47:0] den,
	output logic signed [47:0] k0,
	output logic signed [47:0] k1,
	output logic               done
);
	import pvkf_pkg::*;

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic        done_q;
	logic [47:0] d_q;
	logic        zero_q;
	logic [1:0]  neg_q;
	logic [1:0]  ovf_q;
	logic [47:0] rem_q [2];
	logic [47:0] sh_q  [2];
	logic [47:0] quo_q [2];

	logic [47:0]        rem_d [2];
	logic [1:0]         qb_d  [2];
	logic signed [47:0] k_d   [2];

	always_comb begin
		logic [48:0] r1, r2;
		for (int l = 0; l < 2; l++) begin
			r1 = {rem_q[l], sh_q[l][47]};
			qb_d[l][1] = r1 >= {1'b0, d_q};
			if (qb_d[l][1]) r1 = r1 - {1'b0, d_q};
			r2 = {r1[47:0], sh_q[l][46]};
			qb_d[l][0] = r2 >= {1'b0, d_q};
			if (qb_d[l][0]) r2 = r2 - {1'b0, d_q};
			rem_d[l] = r2[47:0];
			if (zero_q) begin
				k_d[l] = '0;
			end else if (ovf_q[l]) begin
				k_d[l] = neg_q[l] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
			end else begin
				k_d[l] = neg_q[l] ? 48'(48'd0 - quo_q[l]) : quo_q[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 5'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd23) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [47:0] un;
		logic [47:0] dm;
		dm = mag48(den);
		if (start) begin
			d_q    <= dm;
			zero_q <= den == '0;
			for (int l = 0; l < 2; l++) begin
				un = mag48(l == 0 ? num0 : num1);
				neg_q[l] <= (l == 0 ? num0[47] : num1[47]) ^ den[47];
				// quotient of 2^47 or more saturates; the top 24 dividend bits give no quotient
				ovf_q[l] <= {23'b0, un} >= {dm, 23'b0};
				rem_q[l] <= {24'b0, un[47:24]};
				sh_q[l]  <= {un[23:0], 24'b0};
				quo_q[l] <= '0;
			end
		end else if (busy_q) begin
			for (int l = 0; l < 2; l++) begin
				rem_q[l] <= rem_d[l];
				sh_q[l]  <= {sh_q[l][45:0], 2'b00};
				quo_q[l] <= {quo_q[l][45:0], qb_d[l]};
			end
		end
	end

	assign k0   = k_d[0];
	assign k1   = k_d[1];
	assign done = done_q;

endmodule

[sv/pvkf_datapath.sv]
// Filter datapath: state, configuration, operand selection and write-back.
module pvkf_datapath #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pvkf_pkg::dp_cmd_t    cmd,
	output pvkf_pkg::dp_status_t status,
	input  logic signed [31:0]   in_distance,
	input  logic signed [31:0]   in_accel,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	output logic signed [31:0]   out_distance,
	output logic signed [31:0]   out_velocity
);
	import pvkf_pkg::*;

	localparam int CONV_SH = COV_FRAC - FRAC_BITS;
	localparam logic signed [49:0] MAX48 = 50'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [49:0] MIN48 = 50'sh3_8000_0000_0000;
	localparam logic signed [49:0] MAX32 = 50'sh0_0000_7FFF_FFFF;
	localparam logic signed [49:0] MIN32 = 50'sh3_FFFF_8000_0000;

	function automatic logic signed [47:0] sat48(logic signed [49:0] v);
		if (v > MAX48) return 48'(MAX48);
		if (v < MIN48) return 48'(MIN48);
		return 48'(v);
	endfunction

	function automatic logic signed [31:0] sat32(logic signed [49:0] v);
		if (v > MAX32) return 32'(MAX32);
		if (v < MIN32) return 32'(MIN32);
		return 32'(v);
	endfunction

	function automatic logic signed [47:0] to_cov(logic [31:0] v);
		logic [63:0] w;
		w = 64'(v) << CONV_SH;
		if (w > 64'h0000_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
		return 48'(w);
	endfunction

	logic [31:0]        q_q, r_q;
	logic [16:0]        dt_q;
	logic signed [31:0] pos_q, vel_q, s_q, acc_q;
	logic signed [47:0] p00_q, p01_q, p10_q, p11_q;
	logic signed [47:0] t_q, a_q;
	logic signed [32:0] e_q;
	logic signed [31:0] out_pos_q, out_vel_q;

	logic signed [47:0] dtc, qc, rc, sum_pp, one_k0, den, tt;
	logic signed [47:0] opa, opb, m, k0, k1;
	mul_mode_t          mode;
	logic               mul_done, div_done;

	always_comb begin
		dtc    = to_cov(32'(dt_q));
		qc     = to_cov(q_q);
		rc     = to_cov(r_q);
		sum_pp = sat48(50'(p10_q) + 50'(p01_q));
		one_k0 = sat48((50'sd1 <<< COV_FRAC) - 50'(k0));
		den    = sat48(50'(p00_q) + 50'(rc));
		tt     = sat48(50'(t_q) + 50'(m));
		mode   = '{est_shift: 1'b0, narrow: 1'b0};
		opa    = '0;
		opb    = dtc;
		case (cmd.step)
			S_VP: begin
				opa  = 48'(vel_q);
				opb  = 48'(dt_q);
				mode = '{est_shift: 1'b1, narrow: 1'b1};
			end
			S_VA: begin
				opa  = 48'(acc_q);
				opb  = 48'(dt_q);
				mode = '{est_shift: 1'b1, narrow: 1'b1};
			end
			S_T1: opa = sum_pp;
			S_A:  opa = p11_q;
			S_AA: opa = a_q;
			S_Q:  opa = qc;
			S_QQ: opa = a_q;
			S_K1E: begin
				opa  = k1;
				opb  = 48'(e_q);
				mode = '{est_shift: 1'b0, narrow: 1'b1};
			end
			S_K0E: begin
				opa  = k0;
				opb  = 48'(e_q);
				mode = '{est_shift: 1'b0, narrow: 1'b1};
			end
			S_K1P01: begin
				opa = k1;
				opb = p01_q;
			end
			S_K1P00: begin
				opa = k1;
				opb = p00_q;
			end
			S_OK01: begin
				opa = one_k0;
				opb = p01_q;
			end
			S_OK00: begin
				opa = one_k0;
				opb = p00_q;
			end
			default: opa = '0;
		endcase
	end

	pvkf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mul_start),
		.mode  (mode),
		.a     (opa),
		.b     (opb),
		.res   (m),
		.done  (mul_done)
	);

	pvkf_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num0  (p00_q),
		.num1  (p10_q),
		.den   (den),
		.k0    (k0),
		.k1    (k1),
		.done  (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q   <= PROCESS_NOISE_RST;
			r_q   <= MEASUREMENT_NOISE_RST;
			dt_q  <= SAMPLE_PERIOD_RST;
			pos_q <= '0;
			vel_q <= '0;
			p00_q <= '0;
			p01_q <= '0;
			p10_q <= '0;
			p11_q <= to_cov(PROCESS_NOISE_RST);
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PROCESS_NOISE:     q_q  <= cfg_data;
					CFG_MEASUREMENT_NOISE: r_q  <= cfg_data;
					CFG_SAMPLE_PERIOD:     dt_q <= cfg_data[16:0];
					default: ;
				endcase
			end
			if (cmd.clear) begin
				pos_q <= '0;
				vel_q <= '0;
				p00_q <= '0;
				p01_q <= '0;
				p10_q <= '0;
				p11_q <= qc;
			end
			if (cmd.mul_wb) begin
				case (cmd.step)
					S_VP:  pos_q <= sat32(50'(pos_q) + 50'(m));
					S_VA:  vel_q <= sat32(50'(vel_q) + 50'(m));
					S_AA: begin
						p00_q <= sat48(50'(p00_q) + 50'(tt));
						p01_q <= sat48(50'(p01_q) + 50'(a_q));
						p10_q <= sat48(50'(p10_q) + 50'(a_q));
					end
					S_QQ:    p11_q <= sat48(50'(p11_q) + 50'(m));
					S_K1E:   vel_q <= sat32(50'(vel_q) + 50'(m));
					S_K0E:   pos_q <= sat32(50'(pos_q) + 50'(m));
					S_K1P01: p11_q <= sat48(50'(p11_q) - 50'(m));
					S_K1P00: p10_q <= sat48(50'(p10_q) - 50'(m));
					S_OK01:  p01_q <= m;
					S_OK00:  p00_q <= m;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			s_q   <= in_distance;
			acc_q <= in_accel;
		end
		if (cmd.mul_wb) begin
			case (cmd.step)
				S_T1: t_q <= m;
				S_A:  a_q <= m;
				S_Q:  a_q <= m;
				default: ;
			endcase
		end
		if (cmd.div_start) begin
			e_q <= 33'(s_q) - 33'(pos_q);
		end
		if (cmd.out_load) begin
			out_pos_q <= pos_q;
			out_vel_q <= vel_q;
		end
	end

	assign status.mul_done = mul_done;
	assign status.div_done = div_done;
	assign out_distance    = out_pos_q;
	assign out_velocity    = out_vel_q;

endmodule

[sv/pvkf_ctrl.sv]
// Controller: sequences predict, gain and correct steps over the datapath, or a restart clear.
module pvkf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_restart,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pvkf_pkg::dp_cmd_t    cmd,
	input  pvkf_pkg::dp_status_t status
);
	import pvkf_pkg::*;

	ctrl_state_t state_q, state_d;
	step_t       step_q, step_d;
	logic        out_valid_q;

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cmd      = '0;
		cmd.step = step_q;
		in_ready = state_q == ST_IDLE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_restart) begin
						cmd.clear = 1'b1;
						state_d   = ST_OUT;
					end else begin
						step_d  = S_VP;
						state_d = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				cmd.mul_start = 1'b1;
				state_d       = ST_MWAIT;
			end
			ST_MWAIT: begin
				if (status.mul_done) begin
					cmd.mul_wb = 1'b1;
					case (step_q)
						S_QQ:   state_d = ST_DIV;
						S_OK00: state_d = ST_OUT;
						default: begin
							step_d  = step_t'(step_q + 4'd1);
							state_d = ST_MUL;
						end
					endcase
				end
			end
			ST_DIV: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DWAIT;
			end
			ST_DWAIT: begin
				if (status.div_done) begin
					step_d  = S_K1E;
					state_d = ST_MUL;
				end
			end
			ST_OUT: begin
				// hold until the result register is free or being drained
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= S_VP;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		status.mul_done |-> state_q == ST_MWAIT)
		else $error("multiplier finished outside its wait state");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> state_q == ST_DWAIT)
		else $error("divider finished outside its wait state");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !cmd.out_load)
		else $error("pending result overwritten");

	a_start_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_MUL || state_q == ST_OUT))
		else $error("accepted item did not start processing");

endmodule

[sv/position_velocity_kalman_filter.sv]
// Top level of the two-state position and velocity Kalman filter.
//
//   channel | dir | payload                                          | transfer
//   meas    | in  | measured_distance, measured_accel, restart        | valid & ready
//   est     | out | filtered_distance, estimated_velocity            | valid & ready
//   cfg     | in  | index, data (process, measurement noise, period) | valid & ready
//
// One item at a time: an update runs 13 multiplies on one shared multiplier
// (four 24x24 partial products) and one run of the two-lane gain divider.
// Reset restores the register defaults and clears the estimate. The result
// sits in an output register, so est may stall while the next item is taken;
// a finished update waits only if that register is still full.
module position_velocity_kalman_filter #(
	parameter int FRAC_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	pvkf_in_if.sink    meas,
	pvkf_out_if.source est,
	pvkf_cfg_if.sink   cfg
);
	import pvkf_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg.ready = 1'b1;

	pvkf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (meas.valid),
		.in_restart(meas.restart),
		.in_ready  (meas.ready),
		.out_valid (est.valid),
		.out_ready (est.ready),
		.cmd       (cmd),
		.status    (status)
	);

	pvkf_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.in_distance (meas.measured_distance),
		.in_accel    (meas.measured_accel),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.out_distance(est.filtered_distance),
		.out_velocity(est.estimated_velocity)
	);

endmodule

[tb/sv/pvkf_tb_pkg.sv]
// Filter state, predictor arithmetic and stimulus row type for the testbench.
package pvkf_tb_pkg;
	import pvkf_pkg::*;

	typedef struct {
		logic [31:0] q;
		logic [31:0] r;
		logic [16:0] dt;
	} filt_cfg_t;

	typedef struct {
		longint pos;
		longint vel;
		longint p00;
		longint p01;
		longint p10;
		longint p11;
	} filt_state_t;

	typedef struct {
		logic signed [31:0] distance;
		logic signed [31:0] accel;
		logic               restart;
		logic               known;
		logic signed [31:0] exp_dist;
		logic signed [31:0] exp_vel;
	} meas_row_t;

	function automatic longint clamp(logic signed [127:0] v, int bits);
		logic signed [127:0] mx;
		mx = (128'sd1 <<< (bits - 1)) - 1;
		if (v > mx) return longint'(mx);
		if (v < -mx - 1) return longint'(-mx - 1);
		return longint'(v);
	endfunction

	// Exact product, truncate toward zero, then clamp.
	function automatic longint mul_trunc(longint a, longint b, int sh, int bits);
		logic signed [127:0] p;
		logic        [127:0] m;
		p = 128'(a) * 128'(b);
		m = p < 0 ? 128'(-p) : 128'(p);
		m = m >> sh;
		p = p < 0 ? -$signed(m) : $signed(m);
		return clamp(p, bits);
	endfunction

	function automatic longint gain_div(longint num, longint den);
		logic signed [127:0] n, quot;
		if (den == 0) return 0;
		n = 128'(num) <<< COV_FRAC;
		quot = n / 128'(den);
		return clamp(quot, COV_W);
	endfunction

	function automatic longint to_q24(logic [31:0] v);
		return clamp(128'(v) <<< (COV_FRAC - 16), COV_W);
	endfunction

	function automatic longint add_sat(longint a, longint b, int bits);
		return clamp(128'(a) + 128'(b), bits);
	endfunction

	function automatic void filter_clear(ref filt_state_t s, input filt_cfg_t c);
		s.pos = 0; s.vel = 0; s.p00 = 0; s.p01 = 0; s.p10 = 0;
		s.p11 = to_q24(c.q);
	endfunction

	function automatic void filter_update(ref filt_state_t s, input filt_cfg_t c,
			input logic signed [31:0] distance, input logic signed [31:0] accel,
			output logic signed [31:0] o_dist, output logic signed [31:0] o_vel);
		longint dtf, dtc, qc, rc, t, den, k0, k1, e, one_k0, p00, p01, p10, p11;
		dtf = longint'(c.dt);
		dtc = to_q24({15'd0, c.dt});
		qc = to_q24(c.q);
		rc = to_q24(c.r);
		s.pos = add_sat(s.pos, mul_trunc(s.vel, dtf, 16, EST_W), EST_W);
		s.vel = add_sat(s.vel, mul_trunc(longint'(accel), dtf, 16, EST_W), EST_W);
		p00 = s.p00; p01 = s.p01; p10 = s.p10; p11 = s.p11;
		t = add_sat(p10, p01, COV_W);
		t = add_sat(mul_trunc(t, dtc, COV_FRAC, COV_W),
			mul_trunc(mul_trunc(p11, dtc, COV_FRAC, COV_W), dtc, COV_FRAC, COV_W), COV_W);
		p00 = add_sat(p00, t, COV_W);
		t = mul_trunc(p11, dtc, COV_FRAC, COV_W);
		p01 = add_sat(p01, t, COV_W);
		p10 = add_sat(p10, t, COV_W);
		t = mul_trunc(mul_trunc(qc, dtc, COV_FRAC, COV_W), dtc, COV_FRAC, COV_W);
		p11 = add_sat(p11, t, COV_W);
		den = add_sat(p00, rc, COV_W);
		k0 = gain_div(p00, den);
		k1 = gain_div(p10, den);
		e = longint'(distance) - s.pos;
		s.vel = add_sat(s.vel, mul_trunc(k1, e, COV_FRAC, EST_W), EST_W);
		s.pos = add_sat(s.pos, mul_trunc(k0, e, COV_FRAC, EST_W), EST_W);
		p11 = add_sat(p11, -mul_trunc(k1, p01, COV_FRAC, COV_W), COV_W);
		p10 = add_sat(p10, -mul_trunc(k1, p00, COV_FRAC, COV_W), COV_W);
		one_k0 = add_sat(longint'(1) << COV_FRAC, -k0, COV_W);
		p01 = mul_trunc(one_k0, p01, COV_FRAC, COV_W);
		p00 = mul_trunc(one_k0, p00, COV_FRAC, COV_W);
		s.p00 = p00; s.p01 = p01; s.p10 = p10; s.p11 = p11;
		o_dist = 32'(s.pos);
		o_vel = 32'(s.vel);
	endfunction

endpackage

[tb/sv/tb_top.sv]
// Self-checking testbench of the position and velocity Kalman filter.
module tb_top;
	import pvkf_pkg::*;
	import pvkf_tb_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pvkf_in_if  meas();
	pvkf_out_if est();
	pvkf_cfg_if cfg();

	position_velocity_kalman_filter i_dut (
		.clk(clk), .arst_n(arst_n), .meas(meas.sink), .est(est.source), .cfg(cfg.sink)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	typedef struct {
		logic signed [31:0] distance;
		logic signed [31:0] vel;
	} estimate_t;

	filt_cfg_t   cur_cfg;
	filt_state_t cur_state;
	estimate_t   pending_estimates[$];
	int          error_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          recv_hold = 1'b0;
	int          idle_cycles = 0;

	initial begin
		meas.valid = 1'b0; meas.measured_distance = '0; meas.measured_accel = '0;
		meas.restart = 1'b0;
		est.ready = 1'b0;
		cfg.valid = 1'b0; cfg.index = CFG_PROCESS_NOISE; cfg.data = '0;
	end

	// Receiver: random stalls plus an optional long hold-off.
	always @(posedge clk) begin
		if (arst_n)
			est.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
	end

	// Compare every estimate transfer with the oldest prediction.
	always @(posedge clk) begin
		estimate_t want;
		if (arst_n && est.valid && est.ready) begin
			if (pending_estimates.size() == 0) begin
				$error("unexpected estimate %h %h", est.filtered_distance,
					est.estimated_velocity);
				error_count++;
			end else begin
				want = pending_estimates.pop_front();
				if (est.filtered_distance !== want.distance) begin
					$error("filtered_distance: expected %h, got %h", want.distance,
						est.filtered_distance);
					error_count++;
				end
				if (est.estimated_velocity !== want.vel) begin
					$error("estimated_velocity: expected %h, got %h", want.vel,
						est.estimated_velocity);
					error_count++;
				end
			end
		end
	end

	// Watchdog: count cycles with no transfer anywhere.
	always @(posedge clk) begin
		if ((meas.valid && meas.ready) || (est.valid && est.ready) || (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		case (idx)
			CFG_PROCESS_NOISE:     cur_cfg.q = value;
			CFG_MEASUREMENT_NOISE: cur_cfg.r = value;
			default:               cur_cfg.dt = value[16:0];
		endcase
		@(posedge clk);
	endtask

	task automatic drain_estimates();
		while (pending_estimates.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic apply_settings(logic [31:0] q, logic [31:0] r, logic [16:0] dt);
		drain_estimates();
		write_reg(CFG_PROCESS_NOISE, q);
		write_reg(CFG_MEASUREMENT_NOISE, r);
		write_reg(CFG_SAMPLE_PERIOD, {15'd0, dt});
	endtask

	// Offer one measurement, predict at the transfer, optionally check a known answer.
	task automatic send_meas(meas_row_t row);
		estimate_t nxt;
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		meas.valid <= 1'b1;
		meas.measured_distance <= row.distance;
		meas.measured_accel <= row.accel;
		meas.restart <= row.restart;
		@(posedge clk);
		while (!meas.ready) @(posedge clk);
		if (row.restart) begin
			filter_clear(cur_state, cur_cfg);
			nxt.distance = '0; nxt.vel = '0;
		end else begin
			filter_update(cur_state, cur_cfg, row.distance, row.accel, nxt.distance,
				nxt.vel);
		end
		if (row.known && (nxt.distance !== row.exp_dist || nxt.vel !== row.exp_vel)) begin
			$error("directed row: expected %h %h, predicted %h %h", row.exp_dist,
				row.exp_vel, nxt.distance, nxt.vel);
			error_count++;
		end
		pending_estimates.push_back(nxt);
		meas.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic meas_row_t row_of(logic signed [31:0] d, logic signed [31:0] a,
			logic rs, logic kn);
		meas_row_t r;
		r.distance = d; r.accel = a; r.restart = rs; r.known = kn;
		r.exp_dist = '0; r.exp_vel = '0;
		return r;
	endfunction

	function automatic logic signed [31:0] rand_dist();
		case ($urandom_range(5))
			0:       return $urandom;
			1:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed(32'($urandom_range(2000000))) - 32'sd1000000;
		endcase
	endfunction

	task automatic random_phase(int count, int idle_pct, int stall_pct);
		meas_row_t row;
		logic signed [31:0] track;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		track = '0;
		for (int n = 0; n < count; n++) begin
			// Mostly a slowly moving target, some wild values and restarts.
			if ($urandom_range(99) < 70) begin
				track = track + $signed(32'($urandom_range(200000))) - 32'sd100000;
				row = row_of(track, $signed(32'($urandom_range(600000))) - 32'sd300000,
					1'b0, 1'b0);
			end else begin
				row = row_of(rand_dist(), $urandom_range(3) == 0 ? $urandom :
					rand_dist(), $urandom_range(19) == 0, 1'b0);
			end
			send_meas(row);
		end
	endtask

	meas_row_t directed_rows[$];

	initial begin
		cur_cfg.q = PROCESS_NOISE_RST;
		cur_cfg.r = MEASUREMENT_NOISE_RST;
		cur_cfg.dt = SAMPLE_PERIOD_RST;
		filter_clear(cur_state, cur_cfg);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Restart gives zeros; zero measurements from reset stay zero.
		directed_rows.push_back(row_of(32'sd0, 32'sd0, 1'b1, 1'b1));
		directed_rows.push_back(row_of(32'sd0, 32'sd0, 1'b0, 1'b1));
		directed_rows.push_back(row_of(32'sh7fffffff, 32'sh7fffffff, 1'b0, 1'b0));
		directed_rows.push_back(row_of(32'sh80000000, 32'sh80000000, 1'b0, 1'b0));
		directed_rows.push_back(row_of(32'sh7fffffff, 32'sh80000000, 1'b0, 1'b0));
		directed_rows.push_back(row_of(32'sh55555555, 32'shaaaaaaaa, 1'b0, 1'b0));
		directed_rows.push_back(row_of(32'shaaaaaaaa, 32'sh55555555, 1'b0, 1'b0));
		directed_rows.push_back(row_of(32'sh12345678, 32'sh80000000, 1'b1, 1'b1));
		directed_rows.push_back(row_of(32'sh00010000, 32'sh00010000, 1'b0, 1'b0));
		directed_rows.push_back(row_of(-32'sh00010000, 32'sh00000000, 1'b0, 1'b0));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		foreach (directed_rows[i]) send_meas(directed_rows[i]);

		// Extreme settings: zero q, maximal q and r, period 0 and above range.
		apply_settings(32'd0, 32'd1, 17'd66);
		for (int i = 0; i < 5; i++) send_meas(row_of(rand_dist(), rand_dist(), 1'b0, 1'b0));
		apply_settings(32'hffffffff, 32'hffffffff, 17'd65536);
		for (int i = 0; i < 5; i++) send_meas(row_of(rand_dist(), rand_dist(), 1'b0, 1'b0));
		apply_settings(32'h00000100, 32'h00000100, 17'd0);
		send_meas(row_of(32'sd0, 32'sd0, 1'b1, 1'b1));
		for (int i = 0; i < 4; i++) send_meas(row_of(rand_dist(), rand_dist(), 1'b0, 1'b0));
		apply_settings(32'h0001ffff, 32'h7fffffff, 17'h1ffff);
		for (int i = 0; i < 4; i++) send_meas(row_of(rand_dist(), rand_dist(), 1'b0, 1'b0));

		apply_settings(PROCESS_NOISE_RST, MEASUREMENT_NOISE_RST, SAMPLE_PERIOD_RST);
		random_phase(300, 0, 0);

		// Long receiver hold-off while the sender keeps offering.
		fork
			begin
				recv_hold = 1'b1;
				repeat (600) @(posedge clk);
				recv_hold = 1'b0;
			end
			random_phase(4, 0, 0);
		join

		apply_settings($urandom, $urandom_range(32'hffffffff, 1),
			17'($urandom_range(65536, 66)));
		random_phase(300, 73, 0);
		// Sender pauses until everything has come back.
		drain_estimates();
		apply_settings($urandom_range(1 << 20), $urandom_range(1 << 20, 1),
			17'($urandom_range(4000, 66)));
		random_phase(300, 0, 73);
		apply_settings($urandom_range(1 << 18), $urandom_range(1 << 22, 1),
			17'($urandom_range(65536, 66)));
		random_phase(300, 37, 37);
		random_phase(150, 0, 0);

		recv_stall_pct = 0;
		drain_estimates();
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[sim.f]
sv/pvkf_pkg.sv
sv/pvkf_ifs.sv
sv/pvkf_mul.sv
sv/pvkf_div.sv
sv/pvkf_datapath.sv
sv/pvkf_ctrl.sv
sv/position_velocity_kalman_filter.sv
tb/sv/pvkf_tb_pkg.sv
tb/sv/tb_top.sv
